// ===== design/ird_pkg.sv =====
// Shared constants and types for the input-restricted ring deque.
package ird_pkg;

    localparam int SLOTS = 8;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_DEL_FRONT = 2'd1;
    localparam logic [1:0] OP_DEL_REAR  = 2'd2;
    localparam logic [1:0] OP_STATUS    = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured operation
    } ird_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ird_stat_t;

endpackage

// ===== design/ird_ctrl.sv =====
// Controller sequencing accept, execute and result hand-off.
module ird_ctrl
    import ird_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ird_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ird_dpath.sv =====
// Datapath: slot store, front and rear pointers, and result registers.
module ird_dpath
    import ird_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ird_cmd_t                 cmd,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] data_in,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data_out,
    output ird_stat_t                flags
);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(SLOTS - 1)) return '0;
        return p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        if (p == '0) return PTR_W'(SLOTS - 1);
        return p - 1'b1;
    endfunction

    logic [DATA_W-1:0] mem [SLOTS];

    logic [1:0]              op_reg;
    logic [DATA_W-1:0]       din_reg;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    hit_reg, hit_next;
    logic [DATA_W-1:0]       rd_data_reg;
    logic [PTR_W-1:0]        rd_addr;
    logic [PTR_W-1:0]        wr_addr;
    logic                    wr_en;
    logic                    is_full;
    logic                    no_entries;

    assign no_entries = (head_reg == tail_reg);
    assign is_full    = (head_reg == ptr_inc(tail_reg));

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        stat_next = STAT_OK;
        hit_next  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = ptr_inc(tail_reg);
        rd_addr   = tail_reg;
        case (op_reg)
            OP_INSERT: begin
                if (is_full) begin
                    stat_next = STAT_OVERFLOW;
                end else begin
                    tail_next = ptr_inc(tail_reg);
                    wr_en     = cmd.exec;
                end
            end
            OP_DEL_FRONT: begin
                if (no_entries) begin
                    stat_next = STAT_UNDERFLOW;
                end else begin
                    head_next = ptr_inc(head_reg);
                    rd_addr   = ptr_inc(head_reg);
                    hit_next  = 1'b1;
                end
            end
            OP_DEL_REAR: begin
                if (no_entries) begin
                    stat_next = STAT_UNDERFLOW;
                end else begin
                    tail_next = ptr_dec(tail_reg);
                    hit_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= din_reg;
        if (cmd.exec) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= opcode;
            din_reg <= data_in;
        end
        if (cmd.exec) begin
            stat_reg <= stat_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else if (cmd.exec) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Zero the data field unless a delete actually removed an entry.
    assign status      = stat_reg;
    assign data_out    = hit_reg ? rd_data_reg : '0;
    assign flags.empty = no_entries;
    assign flags.full  = is_full;

    a_overflow_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_reg == OP_INSERT && is_full
        |=> $stable(tail_reg) && $stable(head_reg) && stat_reg == STAT_OVERFLOW)
        else $error("overflowing insert moved a pointer");

    a_underflow_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (op_reg == OP_DEL_FRONT || op_reg == OP_DEL_REAR) && no_entries
        |=> $stable(tail_reg) && $stable(head_reg) && stat_reg == STAT_UNDERFLOW
            && !hit_reg)
        else $error("delete on empty deque changed state");

    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_reg == OP_STATUS
        |=> $stable(tail_reg) && $stable(head_reg) && data_out == '0)
        else $error("status-only item changed state");

    a_insert_keeps_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_reg == OP_INSERT |=> $stable(head_reg))
        else $error("insert moved the front pointer");

endmodule

// ===== design/input_restricted_ring_deque.sv =====
// An accepted item is applied in the execute state; its result is registered
// there and presented in the output state, where it can be taken.
// A new item is taken only once the last result is delivered (accept, execute,
// deliver), as the controller sequence sets; the slot read is registered.
// Output stalls hold the result and keep the input closed until it is taken.
// Reset (aresetn low, synchronous): pointers go to zero and the deque is empty;
// slot contents stay undefined until written, with no clearing pass.
module input_restricted_ring_deque
    import ird_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data_out
    output logic [3:0]  m_tuser    // [1:0] status, [2] empty_flag, [3] full_flag
);

    ird_cmd_t              cmd;
    ird_stat_t             flags;
    logic [1:0]            status;
    logic signed [DATA_W-1:0] data_out;

    ird_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ird_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .opcode   (s_tuser),
        .data_in  (s_tdata),
        .status   (status),
        .data_out (data_out),
        .flags    (flags)
    );

    assign m_tdata = data_out;
    assign m_tuser = {flags.full, flags.empty, status};

endmodule
